### src/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine: shared definitions
// Number format, field widths, register indexes and reset values used by the
// channel interfaces and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // Signed fixed point coordinates, Q4.28
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 28;

  // Field widths
  localparam int COL_BITS   = 12;
  localparam int ROW_BITS   = 12;
  localparam int WIDTH_BITS = 13;
  localparam int LIMIT_BITS = 16;

  // Largest divisor used for the real coordinate step
  localparam int MAX_WIDTH  = 4096;

  // Shared signed multiplier: one sign bit over a coordinate magnitude
  localparam int MUL_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  // Product after the floor shift by the fraction bits
  localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
  // Square of a coordinate after the shift, unsigned
  localparam int SQ_BITS    = 2 * COORD_BITS - 1 - FRAC_BITS;
  // Real-step numerator (span * column) and its divider counter
  localparam int NUM_BITS      = COORD_BITS + COL_BITS;
  localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

  // Escape threshold |z|^2 >= 4.0
  localparam logic [SQ_BITS:0] FOUR_Q = (SQ_BITS + 1)'(64'd4 << FRAC_BITS);

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_REAL  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_REAL = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = CFG_INDEX_BITS'(3);

  // Register reset values: left -2.0, right 1.0
  localparam logic [COORD_BITS-1:0] LEFT_RESET  = COORD_BITS'(-(longint'(2) <<< FRAC_BITS));
  localparam logic [COORD_BITS-1:0] RIGHT_RESET = COORD_BITS'(longint'(1) <<< FRAC_BITS);
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1024);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(256);

endpackage

`default_nettype wire

### src/mbe_if.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine: channel interfaces
// Valid/ready channels for pixel requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Pixel request: row, column and imaginary part of c
interface mbe_pixel_if import mbe_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ROW_BITS-1:0]          row_index;
  logic [COL_BITS-1:0]          pixel_column;
  logic signed [COORD_BITS-1:0] c_imag;

  modport source (output valid, output row_index, output pixel_column, output c_imag,
                  input ready);
  modport sink   (input valid, input row_index, input pixel_column, input c_imag,
                  output ready);
endinterface

// Result: echoed position and escape count
interface mbe_result_if import mbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ROW_BITS-1:0]   out_row;
  logic [COL_BITS-1:0]   out_column;
  logic [LIMIT_BITS-1:0] iteration_count;

  modport source (output valid, output out_row, output out_column, output iteration_count,
                  input ready);
  modport sink   (input valid, input out_row, input out_column, input iteration_count,
                  output ready);
endinterface

// Register write: index and data
interface mbe_cfg_if import mbe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine
// Iterates z = z*z + c in signed Q4.28 for one pixel at a time.
// ----------------------------------------------------------------------------
// One pixel request is taken when the engine is idle. It first forms the real
// part of c as left + span*column/width: one multiply on the shared 33x33
// signed multiplier, then a restoring divider that produces one quotient bit
// per cycle. The escape loop then reuses the same multiplier three times per
// iteration (zr*zi, zr^2, zi^2), stepping through S_UPD, S_SQR, S_SQI and
// S_TEST. A pixel runs at most iteration_limit - 1 iterations. If the
// previous result is still waiting in the output register, the finished pixel
// holds until that result is taken. The result sits in an output register, so
// the next request is taken while it waits. Registers must be written between
// pixels only; the engine itself does not enforce this. Arithmetic overflow in
// the iteration update counts as an escape; the real step saturates instead.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mbe_cfg_if.sink       cfg,
  mbe_pixel_if.sink     pixel,
  mbe_result_if.source  result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV,
    S_SAT,
    S_ISSUE,
    S_UPD,
    S_SQR,
    S_SQI,
    S_TEST,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [COORD_BITS-1:0] left_real;
  logic signed [COORD_BITS-1:0] right_real;
  logic [WIDTH_BITS-1:0]        image_width;
  logic [LIMIT_BITS-1:0]        iteration_limit;

  // Request payload: position held for the result, imaginary part for the loop
  logic [ROW_BITS-1:0]          row_q;
  logic [COL_BITS-1:0]          col_q;
  logic signed [COORD_BITS-1:0] c_imag_q;

  // Datapath
  logic signed [PROD_BITS-1:0]  prod;
  logic [NUM_BITS-1:0]          div_num;
  logic [WIDTH_BITS-1:0]        div_rem;
  logic [DIV_CNT_BITS-1:0]      div_cnt;
  logic signed [COORD_BITS-1:0] c_real;
  logic signed [COORD_BITS-1:0] zr;
  logic signed [COORD_BITS-1:0] zi;
  logic [SQ_BITS-1:0]           zr2;
  logic [SQ_BITS-1:0]           zi2;
  logic                         ovf;
  logic [LIMIT_BITS-1:0]        rem;
  logic [LIMIT_BITS-1:0]        cnt;

  // Output register
  logic                         res_valid;
  logic [ROW_BITS-1:0]          res_row;
  logic [COL_BITS-1:0]          res_col;
  logic [LIMIT_BITS-1:0]        res_count;

  // --------------------------------------------------------------------------
  // Register writes
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_real       <= signed'(LEFT_RESET);
      right_real      <= signed'(RIGHT_RESET);
      image_width     <= WIDTH_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LEFT_REAL:   left_real       <= signed'(cfg.data[COORD_BITS-1:0]);
        REG_RIGHT_REAL:  right_real      <= signed'(cfg.data[COORD_BITS-1:0]);
        REG_IMAGE_WIDTH: image_width     <= cfg.data[WIDTH_BITS-1:0];
        REG_ITER_LIMIT:  iteration_limit <= cfg.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Real coordinate step: span magnitude, clamped divisor, saturating offset
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS:0] span;
  logic                       span_neg;
  logic [COORD_BITS:0]        span_abs;
  logic [WIDTH_BITS-1:0]      w_eff;

  assign span     = (COORD_BITS + 1)'(right_real) - (COORD_BITS + 1)'(left_real);
  assign span_neg = span[COORD_BITS];
  assign span_abs = span_neg ? (COORD_BITS + 1)'(-span) : (COORD_BITS + 1)'(span);

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (image_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  // One restoring divider step
  logic [WIDTH_BITS:0]   trial;
  logic                  trial_ge;
  logic [WIDTH_BITS-1:0] trial_sub;

  assign trial     = {div_rem, div_num[NUM_BITS-1]};
  assign trial_ge  = trial >= (WIDTH_BITS + 1)'(w_eff);
  assign trial_sub = WIDTH_BITS'(trial - (WIDTH_BITS + 1)'(w_eff));

  // Offset of left edge in excess form, moved by the quotient and clamped
  logic [COORD_BITS-1:0]        off;
  logic [NUM_BITS:0]            off_up;
  logic [NUM_BITS:0]            off_dn;
  logic [COORD_BITS-1:0]        off_sat;
  logic signed [COORD_BITS-1:0] c_real_next;

  assign off    = {~left_real[COORD_BITS-1], left_real[COORD_BITS-2:0]};
  assign off_up = (NUM_BITS + 1)'(off) + (NUM_BITS + 1)'(div_num);
  assign off_dn = (NUM_BITS + 1)'(off) - (NUM_BITS + 1)'(div_num);

  always_comb begin
    if (!span_neg) begin
      off_sat = (off_up[NUM_BITS:COORD_BITS] != '0) ? '1 : off_up[COORD_BITS-1:0];
    end else begin
      off_sat = off_dn[NUM_BITS] ? '0 : off_dn[COORD_BITS-1:0];
    end
  end

  assign c_real_next = signed'({~off_sat[COORD_BITS-1], off_sat[COORD_BITS-2:0]});

  // --------------------------------------------------------------------------
  // Shared multiplier operand select
  // --------------------------------------------------------------------------
  logic signed [MUL_BITS-1:0]  mul_a;
  logic signed [MUL_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0] prod_next;

  always_comb begin
    mul_a = MUL_BITS'(zr);
    mul_b = MUL_BITS'(zi);
    case (state)
      S_IDLE: begin
        mul_a = signed'(span_abs);
        mul_b = signed'(MUL_BITS'(pixel.pixel_column));
      end
      S_SQR:   mul_b = MUL_BITS'(zr);
      S_SQI:   mul_a = MUL_BITS'(zi);
      default: ;
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Iteration update: floor-scaled products, sums and range checks
  // --------------------------------------------------------------------------
  localparam int NZI_BITS = SHIFT_BITS + 2;
  localparam int NZR_BITS = SQ_BITS + 2;

  logic signed [SHIFT_BITS-1:0] t_q;
  logic signed [NZI_BITS-1:0]   nzi_w;
  logic signed [NZR_BITS-1:0]   nzr_w;
  logic                         ovf_t;
  logic                         ovf_i;
  logic                         ovf_r;

  assign t_q   = prod[PROD_BITS-1:FRAC_BITS];
  assign ovf_t = t_q[SHIFT_BITS-1:COORD_BITS-1]
                 != {(SHIFT_BITS - COORD_BITS + 1){t_q[COORD_BITS-1]}};

  // zi' = 2*zr*zi + ci
  assign nzi_w = NZI_BITS'(signed'({t_q, 1'b0})) + NZI_BITS'(c_imag_q);
  assign ovf_i = nzi_w[NZI_BITS-1:COORD_BITS-1]
                 != {(NZI_BITS - COORD_BITS + 1){nzi_w[COORD_BITS-1]}};

  // zr' = zr^2 - zi^2 + cr
  assign nzr_w = NZR_BITS'(signed'({1'b0, zr2})) - NZR_BITS'(signed'({1'b0, zi2}))
                 + NZR_BITS'(c_real);
  assign ovf_r = nzr_w[NZR_BITS-1:COORD_BITS-1]
                 != {(NZR_BITS - COORD_BITS + 1){nzr_w[COORD_BITS-1]}};

  // Escape test on the fresh squares
  logic [SQ_BITS-1:0] sq_new;
  logic [SQ_BITS:0]   mag_sum;
  logic               escaped;

  assign sq_new  = prod[FRAC_BITS +: SQ_BITS];
  assign mag_sum = (SQ_BITS + 1)'(zr2) + (SQ_BITS + 1)'(sq_new);
  assign escaped = ovf || (mag_sum >= FOUR_Q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign pixel.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // A finishing pixel refills the output register in S_DONE instead
      if (result.valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            row_q    <= pixel.row_index;
            col_q    <= pixel.pixel_column;
            c_imag_q <= pixel.c_imag;
            prod     <= prod_next;
            state    <= S_DIV_LOAD;
          end
        end

        S_DIV_LOAD: begin
          div_num <= prod[NUM_BITS-1:0];
          div_rem <= '0;
          div_cnt <= DIV_CNT_BITS'(NUM_BITS - 1);
          state   <= S_DIV;
        end

        // One quotient bit per cycle
        S_DIV: begin
          div_rem <= trial_ge ? trial_sub : trial[WIDTH_BITS-1:0];
          div_num <= {div_num[NUM_BITS-2:0], trial_ge};
          if (div_cnt == '0) begin
            state <= S_SAT;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end

        S_SAT: begin
          c_real <= c_real_next;
          zr     <= '0;
          zi     <= '0;
          zr2    <= '0;
          zi2    <= '0;
          ovf    <= 1'b0;
          rem    <= (iteration_limit == '0) ? '0 : iteration_limit - 1'b1;
          state  <= S_ISSUE;
        end

        S_ISSUE: begin
          if (rem == '0) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            prod  <= prod_next;
            state <= S_UPD;
          end
        end

        S_UPD: begin
          zr    <= nzr_w[COORD_BITS-1:0];
          zi    <= nzi_w[COORD_BITS-1:0];
          ovf   <= ovf_t || ovf_i || ovf_r;
          rem   <= rem - 1'b1;
          state <= S_SQR;
        end

        S_SQR: begin
          prod  <= prod_next;
          state <= S_SQI;
        end

        S_SQI: begin
          zr2   <= sq_new;
          prod  <= prod_next;
          state <= S_TEST;
        end

        // Budget check first, then escape, else start the next iteration
        S_TEST: begin
          zi2 <= sq_new;
          if (rem == '0) begin
            cnt   <= '0;
            state <= S_DONE;
          end else if (escaped) begin
            cnt   <= iteration_limit - rem;
            state <= S_DONE;
          end else begin
            prod  <= prod_next;
            state <= S_UPD;
          end
        end

        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_row   <= row_q;
            res_col   <= col_q;
            res_count <= cnt;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = res_valid;
  assign result.out_row         = res_row;
  assign result.out_column      = res_col;
  assign result.iteration_count = res_count;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready |=> state == S_DIV_LOAD)
    else $error("request accepted without starting the real step");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_rem < w_eff)
    else $error("divider remainder not below divisor");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_count == '0) || (res_count < iteration_limit))
    else $error("escape count outside the iteration budget");

  a_done_handoff: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!res_valid || result.ready) |=> state == S_IDLE && res_valid)
    else $error("finished pixel not moved to the output register");

endmodule

`default_nettype wire
